// File: sv/pra_pkg.sv
// Package for the priority resource allocator.
// Holds the request, result and wait-entry types and the mode and status codes.
// No dependencies.
package pra_pkg;

	localparam int unsigned RESULT_LIMIT = 16;

	localparam logic [1:0] MODE_ACQUIRE = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_TICK    = 2'd2;

	localparam logic [2:0] ST_GRANTED  = 3'd0;
	localparam logic [2:0] ST_QUEUED   = 3'd1;
	localparam logic [2:0] ST_REJECTED = 3'd2;
	localparam logic [2:0] ST_HANDOFF  = 3'd3;
	localparam logic [2:0] ST_RETURNED = 3'd4;
	localparam logic [2:0] ST_TIMEOUT  = 3'd5;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  requester;
		logic [7:0]  priority_req;
		logic [15:0] timeout_ticks;
		logic [7:0]  resource;
	} request_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  client;
		logic [7:0]  granted_resource;
		logic [31:0] failures;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [7:0]  client;
		logic [7:0]  prio;
		logic [15:0] remaining;
		logic [15:0] arrival;
	} wait_entry_t;

endpackage

// File: sv/pra_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pra_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/priority_resource_allocator.sv
// Top level of the priority resource allocator: free-ID FIFO, wait list and sequencer.
// Depends on pra_pkg and pra_ram.
//
//  Channel   Ports                    Handshake
//  request   start, request, busy     taken when start is high and busy is low
//  result    result_valid, result     shown for one cycle, cannot be held off
//
// An acquire with a free ID passes through the pop state; a queued or rejected acquire answers from idle.
// A release or a tick runs a scan of the whole wait list, which reads one entry per cycle from the
// wait-list RAM; a release that hands off an ID then passes through the pop state.
// A tick may deliver up to 16 timeouts, one per cycle, during its scan.
// Reset leaves the pool full and the wait list empty; no clearing pass is needed.
// The receiver cannot stall; busy is the only back-pressure on requests.
module priority_resource_allocator
	import pra_pkg::*;
#(
	parameter int unsigned NUM_RESOURCES = 8,
	parameter int unsigned MAX_WAITERS   = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  request_t request,
	output logic     busy,
	output logic     result_valid,
	output result_t  result
);

	localparam int unsigned HW  = NUM_RESOURCES > 1 ? $clog2(NUM_RESOURCES) : 1;
	localparam int unsigned CW  = $clog2(NUM_RESOURCES + 1);
	localparam int unsigned WAW = MAX_WAITERS > 1 ? $clog2(MAX_WAITERS) : 1;
	localparam int unsigned SCW = $clog2(MAX_WAITERS + 1);
	localparam int unsigned EW  = $bits(wait_entry_t);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_POP} state_t;

	state_t                   state_q;
	logic [HW-1:0]            head_q;
	logic [CW-1:0]            count_q;
	logic [NUM_RESOURCES-1:0] free_written_q;
	logic [MAX_WAITERS-1:0]   wait_valid_q;
	logic [15:0]              arrival_q;
	logic [31:0]              failures_q;
	logic                     tick_q;
	logic [SCW-1:0]           cnt_q;
	logic                     pv_q;
	logic [WAW-1:0]           pidx_q;
	logic                     best_found_q;
	logic [WAW-1:0]           best_idx_q;
	logic [7:0]               best_prio_q;
	logic [15:0]              best_age_q;
	logic [7:0]               best_client_q;
	logic [4:0]               n_q;
	logic                     pend_v_q;
	result_t                  pend_q;
	logic [2:0]               pop_status_q;
	logic [7:0]               pop_client_q;

	// Free-ID FIFO storage.
	logic          free_we;
	logic [HW-1:0] free_waddr;
	logic [7:0]    free_rdata;
	logic [CW:0]   tail_sum;
	logic [7:0]    head_id;

	// Wait-list storage.
	logic           wait_we;
	logic [WAW-1:0] wait_waddr;
	wait_entry_t    wait_wdata;
	logic [EW-1:0]  wait_rdata;
	wait_entry_t    entry;

	logic           slot_found;
	logic [WAW-1:0] slot_idx;
	logic [31:0]    failures_inc;
	logic [15:0]    entry_age;
	logic           accept;
	logic           entry_live;
	logic           entry_expired;

	assign accept       = start && (state_q == S_IDLE);
	assign busy         = (state_q != S_IDLE);
	assign failures_inc = (failures_q == 32'hFFFF_FFFF) ? failures_q : failures_q + 32'd1;
	assign entry        = wait_entry_t'(wait_rdata);
	assign entry_age    = arrival_q - entry.arrival;
	assign entry_live   = pv_q && wait_valid_q[pidx_q];
	assign entry_expired = entry.remaining <= 16'd1;

	// Tail position of the FIFO; head + count stays below twice the depth.
	always_comb begin
		tail_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
		if (tail_sum >= (CW+1)'(NUM_RESOURCES)) begin
			tail_sum = tail_sum - (CW+1)'(NUM_RESOURCES);
		end
		free_waddr = tail_sum[HW-1:0];
	end

	// An entry never written still holds its reset identifier, which is its index.
	assign head_id = free_written_q[head_q] ? free_rdata : 8'(head_q);
	assign free_we = accept && (request.mode == MODE_RELEASE)
		&& (count_q < CW'(NUM_RESOURCES));

	always_comb begin
		slot_found = 1'b0;
		slot_idx   = '0;
		for (int i = MAX_WAITERS - 1; i >= 0; i--) begin
			if (!wait_valid_q[i]) begin
				slot_found = 1'b1;
				slot_idx   = WAW'(i);
			end
		end
	end

	always_comb begin
		wait_we    = 1'b0;
		wait_waddr = slot_idx;
		wait_wdata.client    = request.requester;
		wait_wdata.prio      = request.priority_req;
		wait_wdata.remaining = request.timeout_ticks;
		wait_wdata.arrival   = arrival_q;
		if (state_q == S_SCAN) begin
			wait_waddr = pidx_q;
			wait_wdata = entry;
			wait_wdata.remaining = entry.remaining - 16'd1;
			wait_we    = tick_q && entry_live && !entry_expired;
		end else if (accept && request.mode == MODE_ACQUIRE && count_q == '0) begin
			wait_we = slot_found;
		end
	end

	pra_ram #(.WIDTH(8), .DEPTH(NUM_RESOURCES)) u_free_ram (
		.clk   (clk),
		.we    (free_we),
		.waddr (free_waddr),
		.wdata (request.resource),
		.raddr (head_q),
		.rdata (free_rdata)
	);

	pra_ram #(.WIDTH(EW), .DEPTH(MAX_WAITERS)) u_wait_ram (
		.clk   (clk),
		.we    (wait_we),
		.waddr (wait_waddr),
		.wdata (EW'(wait_wdata)),
		.raddr (cnt_q[WAW-1:0]),
		.rdata (wait_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			head_q         <= '0;
			count_q        <= CW'(NUM_RESOURCES);
			free_written_q <= '0;
			wait_valid_q   <= '0;
			arrival_q      <= '0;
			failures_q     <= '0;
			tick_q         <= 1'b0;
			cnt_q          <= '0;
			pv_q           <= 1'b0;
			pidx_q         <= '0;
			best_found_q   <= 1'b0;
			n_q            <= '0;
			pend_v_q       <= 1'b0;
			result_valid   <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (request.mode)
							MODE_ACQUIRE: begin
								result.client           <= request.requester;
								result.granted_resource <= '0;
								result.last             <= 1'b1;
								if (count_q != '0) begin
									pop_status_q <= ST_GRANTED;
									pop_client_q <= request.requester;
									state_q      <= S_POP;
								end else if (slot_found) begin
									wait_valid_q[slot_idx] <= 1'b1;
									arrival_q       <= arrival_q + 16'd1;
									result.status   <= ST_QUEUED;
									result.failures <= failures_q;
									result_valid    <= 1'b1;
								end else begin
									failures_q      <= failures_inc;
									result.status   <= ST_REJECTED;
									result.failures <= failures_inc;
									result_valid    <= 1'b1;
								end
							end
							MODE_RELEASE, MODE_TICK: begin
								if (free_we) begin
									free_written_q[free_waddr] <= 1'b1;
									count_q <= count_q + CW'(1);
								end
								tick_q       <= (request.mode == MODE_TICK);
								cnt_q        <= '0;
								pv_q         <= 1'b0;
								best_found_q <= 1'b0;
								n_q          <= '0;
								pend_v_q     <= 1'b0;
								state_q      <= S_SCAN;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SCAN: begin
					// Read of entry cnt is issued now; the entry read last cycle is judged.
					if (cnt_q != SCW'(MAX_WAITERS)) begin
						pidx_q <= cnt_q[WAW-1:0];
						cnt_q  <= cnt_q + SCW'(1);
						pv_q   <= 1'b1;
					end else begin
						pv_q <= 1'b0;
					end
					if (entry_live) begin
						if (!tick_q) begin
							if (!best_found_q || entry.prio > best_prio_q
								|| (entry.prio == best_prio_q && entry_age > best_age_q)) begin
								best_found_q  <= 1'b1;
								best_idx_q    <= pidx_q;
								best_prio_q   <= entry.prio;
								best_age_q    <= entry_age;
								best_client_q <= entry.client;
							end
						end else if (entry_expired && n_q < 5'(RESULT_LIMIT)) begin
							wait_valid_q[pidx_q] <= 1'b0;
							failures_q <= failures_inc;
							n_q        <= n_q + 5'd1;
							// The held timeout goes out now that a later one follows it.
							if (pend_v_q) begin
								result       <= pend_q;
								result_valid <= 1'b1;
							end
							pend_v_q                <= 1'b1;
							pend_q.status           <= ST_TIMEOUT;
							pend_q.client           <= entry.client;
							pend_q.granted_resource <= '0;
							pend_q.failures         <= failures_inc;
							pend_q.last             <= 1'b0;
						end
					end
					if (cnt_q == SCW'(MAX_WAITERS) && !pv_q) begin
						if (tick_q) begin
							if (pend_v_q) begin
								// The held timeout is the final one; last is its low bit.
								result       <= {pend_q[$bits(result_t)-1:1], 1'b1};
								result_valid <= 1'b1;
							end
							state_q <= S_IDLE;
						end else if (best_found_q && count_q != '0) begin
							wait_valid_q[best_idx_q] <= 1'b0;
							pop_status_q <= ST_HANDOFF;
							pop_client_q <= best_client_q;
							state_q      <= S_POP;
						end else begin
							result.status           <= ST_RETURNED;
							result.client           <= '0;
							result.granted_resource <= '0;
							result.failures         <= failures_q;
							result.last             <= 1'b1;
							result_valid            <= 1'b1;
							state_q                 <= S_IDLE;
						end
					end
				end
				S_POP: begin
					result.status           <= pop_status_q;
					result.client           <= pop_client_q;
					result.granted_resource <= head_id;
					result.failures         <= failures_q;
					result.last             <= 1'b1;
					result_valid            <= 1'b1;
					head_q  <= (head_q == HW'(NUM_RESOURCES - 1)) ? '0 : head_q + HW'(1);
					count_q <= count_q - CW'(1);
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
